// ===== src/qkp_pkg.sv =====
// shared types, codes and constants for the quadrature knob with press timing
package qkp_pkg;

  // result event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_CW    = 3'd1;
  localparam logic [2:0] EV_CCW   = 3'd2;
  localparam logic [2:0] EV_SHORT = 3'd3;
  localparam logic [2:0] EV_LONG  = 3'd4;

  // register indexes, taken from paddr[2]
  localparam logic REG_DETENT = 1'b0;
  localparam logic REG_LONG   = 1'b1;

  // widths and reset values
  localparam int unsigned ACCUM_WIDTH_DEF = 16;
  localparam int unsigned DETENT_W        = 3;
  localparam int unsigned HOLD_W          = 16;
  localparam int unsigned ADDR_W          = 3;
  localparam int unsigned DATA_W          = 32;
  localparam logic [DETENT_W-1:0] DETENT_RST = 3'd2;
  localparam logic [HOLD_W-1:0]   LONG_RST   = 16'd1500;
  localparam logic [HOLD_W-1:0]   HOLD_MAX   = 16'hFFFF;

  // rotation decision handed to the key logic and the result mux
  typedef struct packed {
    logic cw;
    logic ccw;
  } rot_evt_t;

  // quadrature transition table: {prev, cur} -> +1, -1 or 0
  function automatic logic signed [1:0] phase_step(input logic [3:0] idx);
    logic signed [1:0] step;
    step = 2'sd0;
    case (idx) inside
      4'b0001, 4'b0111, 4'b1110, 4'b1000: step = 2'sd1;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: step = -2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

// ===== src/qkp_rot.sv =====
// quadrature decode, saturating step accumulator and detent detection
module qkp_rot #(
  parameter int unsigned ACCUM_WIDTH = qkp_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          primed,
  input  logic                          phase_a,
  input  logic                          phase_b,
  input  logic [qkp_pkg::DETENT_W-1:0]  steps_per_detent,
  output qkp_pkg::rot_evt_t             rot
);

  localparam int unsigned W = ACCUM_WIDTH;
  localparam logic signed [W:0] LIM = signed'({2'b00, {(W-1){1'b1}}});

  logic [1:0]                    prev_phase;
  logic signed [W-1:0]           step_accum;
  logic [1:0]                    cur_phase;
  logic [qkp_pkg::DETENT_W-1:0]  det_eff;
  logic signed [W-1:0]           det_s;
  logic signed [1:0]             step;
  logic signed [W:0]             sum;
  logic signed [W-1:0]           sat;
  logic signed [W-1:0]           step_accum_next;
  logic                          cw;
  logic                          ccw;

  assign cur_phase = {phase_a, phase_b};

  // detent size clamped to 1..4
  always_comb begin
    if (steps_per_detent == '0) begin
      det_eff = qkp_pkg::DETENT_W'(1);
    end else if (steps_per_detent > qkp_pkg::DETENT_W'(4)) begin
      det_eff = qkp_pkg::DETENT_W'(4);
    end else begin
      det_eff = steps_per_detent;
    end
  end
  assign det_s = signed'({{(W-qkp_pkg::DETENT_W){1'b0}}, det_eff});

  // accumulate with saturation, then check detent
  always_comb begin
    step = qkp_pkg::phase_step({prev_phase, cur_phase});
    sum  = {step_accum[W-1], step_accum} + {{(W-1){step[1]}}, step};
    if (sum > LIM) begin
      sat = LIM[W-1:0];
    end else if (sum < -LIM) begin
      sat = signed'(-LIM[W-1:0]);
    end else begin
      sat = sum[W-1:0];
    end
    cw  = primed && (sat >= det_s);
    ccw = primed && !cw && (sat <= -det_s);
    if (cw) begin
      step_accum_next = sat - det_s;
    end else if (ccw) begin
      step_accum_next = sat + det_s;
    end else begin
      step_accum_next = sat;
    end
  end

  assign rot.cw  = cw;
  assign rot.ccw = ccw;

  // state update once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      step_accum <= '0;
    end else if (fire) begin
      prev_phase <= cur_phase;
      if (primed) begin
        step_accum <= step_accum_next;
      end
    end
  end

endmodule

// ===== src/qkp_key.sv =====
// push key hold timer with short and long press detection
module qkp_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic                        primed,
  input  logic                        key_down,
  input  logic                        ms_tick,
  input  qkp_pkg::rot_evt_t           rot,
  input  logic [qkp_pkg::HOLD_W-1:0]  long_press_limit,
  output logic [2:0]                  key_event,
  output logic [qkp_pkg::HOLD_W-1:0]  hold_ms
);

  logic                        key_held;
  logic                        long_fired;
  logic [qkp_pkg::HOLD_W-1:0]  hold_count;
  logic                        key_held_next;
  logic                        long_fired_next;
  logic [qkp_pkg::HOLD_W-1:0]  hold_count_next;

  always_comb begin
    key_held_next   = key_held;
    long_fired_next = long_fired;
    hold_count_next = hold_count;
    key_event       = qkp_pkg::EV_NONE;
    if (primed) begin
      // time runs while held, even on rotation beats
      if (key_held && ms_tick && hold_count != qkp_pkg::HOLD_MAX) begin
        hold_count_next = hold_count + qkp_pkg::HOLD_W'(1);
      end
      // key edges only when no rotation event
      if (!rot.cw && !rot.ccw) begin
        if (key_down && !key_held) begin
          key_held_next   = 1'b1;
          hold_count_next = '0;
          long_fired_next = 1'b0;
        end else if (key_down && key_held) begin
          if (!long_fired && hold_count_next >= long_press_limit) begin
            long_fired_next = 1'b1;
            key_event       = qkp_pkg::EV_LONG;
          end
        end else if (!key_down && key_held) begin
          key_held_next = 1'b0;
          if (!long_fired && hold_count_next < long_press_limit) begin
            key_event = qkp_pkg::EV_SHORT;
          end
        end
      end
    end
  end

  assign hold_ms = key_held_next ? hold_count_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_held   <= 1'b0;
      long_fired <= 1'b0;
      hold_count <= '0;
    end else if (fire) begin
      key_held   <= key_held_next;
      long_fired <= long_fired_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

// ===== src/quadrature_knob_with_press_timing.sv =====
// top level: input register, decode and key logic, result register, register port
//
// Usage: each input beat is one sample of phase_a, phase_b, key_down and
// ms_tick, and gives exactly one result beat of event_res and hold_ms.
// event_res: 0 none, 1 clockwise, 2 counterclockwise, 3 short, 4 long press.
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low.
// A beat accepted into the input register passes on to the result register
// and from there shows at out_valid; an output stall can hold it in between.
// Throughput: one beat per cycle while out_stall is low; the single
// decode/accumulate/key pass between the two registers sets that figure.
// A stall on the output holds the result register; the input register
// still takes one more beat, and in_stall rises only when both are full.
// Registers (APB, byte address 0: steps_per_detent, 4: long_press_limit) must
// be written only while the block is idle; the block does not enforce this.
// Reset clears all state: the first sample afterwards only captures A/B and
// reports no event with hold_ms 0. steps_per_detent resets to 2 and
// long_press_limit to 1500.
module quadrature_knob_with_press_timing #(
  parameter int unsigned ACCUM_WIDTH = qkp_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qkp_pkg::ADDR_W-1:0]  paddr,
  input  logic [qkp_pkg::DATA_W-1:0]  pwdata,
  output logic [qkp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        phase_a,
  input  logic                        phase_b,
  input  logic                        key_down,
  input  logic                        ms_tick,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  event_res,
  output logic [qkp_pkg::HOLD_W-1:0]  hold_ms
);

  logic [qkp_pkg::DETENT_W-1:0]  steps_per_detent;
  logic [qkp_pkg::HOLD_W-1:0]    long_press_limit;
  logic                          cfg_wr;

  logic                          s1_valid;
  logic                          s1_phase_a;
  logic                          s1_phase_b;
  logic                          s1_key_down;
  logic                          s1_ms_tick;
  logic                          primed;
  logic                          in_take;
  logic                          fire;

  qkp_pkg::rot_evt_t             rot;
  logic [2:0]                    key_event;
  logic [qkp_pkg::HOLD_W-1:0]    key_hold_ms;
  logic [2:0]                    event_res_next;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_detent <= qkp_pkg::DETENT_RST;
      long_press_limit <= qkp_pkg::LONG_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        qkp_pkg::REG_DETENT: steps_per_detent <= pwdata[qkp_pkg::DETENT_W-1:0];
        qkp_pkg::REG_LONG:   long_press_limit <= pwdata[qkp_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      qkp_pkg::REG_DETENT:
        prdata = {{(qkp_pkg::DATA_W-qkp_pkg::DETENT_W){1'b0}}, steps_per_detent};
      qkp_pkg::REG_LONG:
        prdata = {{(qkp_pkg::DATA_W-qkp_pkg::HOLD_W){1'b0}}, long_press_limit};
      default: prdata = '0;
    endcase
  end

  // handshake: process when the result register is free or draining
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_phase_a  <= phase_a;
      s1_phase_b  <= phase_b;
      s1_key_down <= key_down;
      s1_ms_tick  <= ms_tick;
    end
  end

  // first processed sample only primes the phase history
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (fire) begin
      primed <= 1'b1;
    end
  end

  qkp_rot #(
    .ACCUM_WIDTH(ACCUM_WIDTH)
  ) u_rot (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .primed           (primed),
    .phase_a          (s1_phase_a),
    .phase_b          (s1_phase_b),
    .steps_per_detent (steps_per_detent),
    .rot              (rot)
  );

  qkp_key u_key (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .primed           (primed),
    .key_down         (s1_key_down),
    .ms_tick          (s1_ms_tick),
    .rot              (rot),
    .long_press_limit (long_press_limit),
    .key_event        (key_event),
    .hold_ms          (key_hold_ms)
  );

  // rotation wins over key events
  always_comb begin
    if (rot.cw) begin
      event_res_next = qkp_pkg::EV_CW;
    end else if (rot.ccw) begin
      event_res_next = qkp_pkg::EV_CCW;
    end else begin
      event_res_next = key_event;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res <= event_res_next;
      hold_ms   <= key_hold_ms;
    end
  end

endmodule

// ===== test/tb_quadrature_knob_with_press_timing.sv =====
// testbench for the quadrature knob with press timing: directed and random samples
module tb_quadrature_knob_with_press_timing;

  // one expected result beat
  typedef struct packed {
    logic [2:0]                 ev;
    logic [qkp_pkg::HOLD_W-1:0] hold;
  } knob_result_t;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [qkp_pkg::ADDR_W-1:0] paddr     = '0;
  logic [qkp_pkg::DATA_W-1:0] pwdata    = '0;
  logic [qkp_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       phase_a   = 1'b0;
  logic                       phase_b   = 1'b0;
  logic                       key_down  = 1'b0;
  logic                       ms_tick   = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [2:0]                 event_res;
  logic [qkp_pkg::HOLD_W-1:0] hold_ms;

  quadrature_knob_with_press_timing dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .phase_a(phase_a), .phase_b(phase_b), .key_down(key_down), .ms_tick(ms_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .hold_ms(hold_ms)
  );

  // knob state as the predictor sees it
  logic [qkp_pkg::DETENT_W-1:0] detent_cfg = qkp_pkg::DETENT_RST;
  logic [qkp_pkg::HOLD_W-1:0]   long_cfg   = qkp_pkg::LONG_RST;
  logic [1:0]                   last_phase = 2'b00;
  bit                           captured   = 1'b0;
  int                           step_sum   = 0;
  bit                           key_seen   = 1'b0;
  bit                           long_done  = 1'b0;
  logic [qkp_pkg::HOLD_W-1:0]   held_ms    = '0;

  knob_result_t expected_results[$];
  knob_result_t want;
  bit           gaps_on = 1'b1;
  int           mismatches = 0;
  int           samples_sent = 0;
  int           setting_phases = 0;
  int           seen_events[5];
  logic [1:0]   last_ab = 2'b00;
  bit           last_key = 1'b0;
  bit           spin_cw = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #2000000;
    $display("quadrature_knob_with_press_timing test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < 50)
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  // gray code position of a phase pair, and back (the map is its own inverse)
  function automatic logic [1:0] gray_swap(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // work out the result of one accepted sample and queue it
  function automatic void predict_knob(input bit a, input bit b, input bit k, input bit t);
    knob_result_t r;
    logic [1:0] cur;
    logic [1:0] moved;
    int det;
    cur = {a, b};
    r.ev = qkp_pkg::EV_NONE;
    if (!captured) begin
      last_phase = cur;
      captured = 1'b1;
    end else begin
      det = (detent_cfg == 0) ? 1 : (detent_cfg > 4) ? 4 : int'(detent_cfg);
      if (key_seen && t && held_ms != qkp_pkg::HOLD_MAX) held_ms = held_ms + 1'b1;
      // one gray position forward is a clockwise step, one back is counterclockwise
      moved = gray_swap(cur) - gray_swap(last_phase);
      if (moved == 2'd1) step_sum = step_sum + 1;
      else if (moved == 2'd3) step_sum = step_sum - 1;
      if (step_sum > 32767) step_sum = 32767;
      if (step_sum < -32767) step_sum = -32767;
      last_phase = cur;
      if (step_sum >= det) begin
        step_sum = step_sum - det;
        r.ev = qkp_pkg::EV_CW;
      end else if (step_sum <= -det) begin
        step_sum = step_sum + det;
        r.ev = qkp_pkg::EV_CCW;
      end else if (k && !key_seen) begin
        key_seen = 1'b1;
        held_ms = '0;
        long_done = 1'b0;
      end else if (k && key_seen) begin
        if (!long_done && held_ms >= long_cfg) begin
          long_done = 1'b1;
          r.ev = qkp_pkg::EV_LONG;
        end
      end else if (!k && key_seen) begin
        key_seen = 1'b0;
        if (!long_done && held_ms < long_cfg) r.ev = qkp_pkg::EV_SHORT;
      end
    end
    r.hold = key_seen ? held_ms : '0;
    expected_results.push_back(r);
  endfunction

  // send one sample beat; leaves valid high so the next beat can follow at once
  task automatic send_sample(input bit a, input bit b, input bit k, input bit t);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    phase_a  <= a;
    phase_b  <= b;
    key_down <= k;
    ms_tick  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_knob(a, b, k, t);
    last_ab = {a, b};
    last_key = k;
    samples_sent++;
  endtask

  // stop input and wait for every expected beat, plus the pipeline depth
  task automatic settle_block;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg_check(input logic idx);
    logic [qkp_pkg::DATA_W-1:0] want_val;
    want_val = (idx == qkp_pkg::REG_DETENT)
             ? {{(qkp_pkg::DATA_W-qkp_pkg::DETENT_W){1'b0}}, detent_cfg}
             : {{(qkp_pkg::DATA_W-qkp_pkg::HOLD_W){1'b0}}, long_cfg};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want_val) report_mismatch("register readback", prdata, want_val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(input logic idx, input logic [qkp_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == qkp_pkg::REG_DETENT) detent_cfg = val[qkp_pkg::DETENT_W-1:0];
    else long_cfg = val[qkp_pkg::HOLD_W-1:0];
    @(posedge clk);
    read_reg_check(idx);
  endtask

  // result checker and random output stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", event_res, 0);
      end else begin
        want = expected_results.pop_front();
        if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
        if (hold_ms !== want.hold) report_mismatch("hold_ms", hold_ms, want.hold);
        if (event_res < 5) seen_events[event_res]++;
      end
    end
    out_stall <= gaps_on && ($urandom_range(99) < 36);
  end

  // first capture, both rotations, invalid jumps and a short press at reset settings
  task automatic test_reset_rotation;
    read_reg_check(qkp_pkg::REG_DETENT);
    read_reg_check(qkp_pkg::REG_LONG);
    setting_phases++;
    send_sample(0, 0, 0, 0);
    send_sample(0, 1, 0, 0);
    send_sample(1, 1, 0, 0);
    send_sample(1, 0, 0, 0);
    send_sample(0, 0, 0, 0);
    send_sample(1, 0, 0, 0);
    send_sample(1, 1, 0, 0);
    send_sample(0, 0, 0, 0);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 0, 0);
    settle_block();
  endtask

  // short and long presses, ticks on release, rotation taking the key samples
  task automatic test_key_timing;
    write_reg(qkp_pkg::REG_DETENT, 1);
    write_reg(qkp_pkg::REG_LONG, 2);
    setting_phases++;
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 0, 0);
    send_sample(1, 1, 1, 0);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 1, 1);
    send_sample(1, 1, 0, 1);
    send_sample(1, 1, 1, 0);
    send_sample(1, 0, 1, 1);
    send_sample(0, 0, 0, 1);
    send_sample(0, 0, 0, 0);
    settle_block();
  endtask

  // zero threshold fires long at once; a zero detent acts as one
  task automatic test_zero_threshold;
    write_reg(qkp_pkg::REG_DETENT, 0);
    write_reg(qkp_pkg::REG_LONG, 0);
    setting_phases++;
    send_sample(0, 0, 1, 0);
    send_sample(0, 0, 1, 0);
    send_sample(0, 0, 0, 0);
    send_sample(1, 0, 0, 0);
    settle_block();
  endtask

  // mostly clean rotation runs with random reversals, jumps and key activity
  task automatic test_random_phase(input logic [qkp_pkg::DETENT_W-1:0] det,
                                   input logic [qkp_pkg::HOLD_W-1:0] lim,
                                   input int n, input bit gaps);
    logic [1:0] pos;
    logic [1:0] ab;
    bit key;
    bit tick;
    int r;
    write_reg(qkp_pkg::REG_DETENT, det);
    write_reg(qkp_pkg::REG_LONG, lim);
    setting_phases++;
    gaps_on = gaps;
    pos = gray_swap(last_ab);
    key = last_key;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6) spin_cw = !spin_cw;
      if (r < 70) pos = spin_cw ? pos + 2'd1 : pos - 2'd1;
      else if (r >= 90) begin
        if (r < 96) pos = pos + 2'd2;
        else pos = 2'($urandom_range(3));
      end
      if ($urandom_range(99) < 12) key = !key;
      tick = 1'($urandom_range(1));
      ab = gray_swap(pos);
      send_sample(ab[1], ab[0], key, tick);
    end
    settle_block();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_rotation();
    test_key_timing();
    test_zero_threshold();
    test_random_phase(3'd1, 16'd3,  225, 1'b1);
    test_random_phase(3'd4, 16'd12, 225, 1'b1);
    test_random_phase(3'd0, 16'd1,  225, 1'b0);
    test_random_phase(3'd2, 16'd0,  225, 1'b1);
    test_random_phase(3'd3, 16'd25, 225, 1'b1);
    test_random_phase(3'd7, 16'd6,  225, 1'b1);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    $display("covered %0d samples over %0d register settings", samples_sent, setting_phases);
    $display("events seen: %0d cw, %0d ccw, %0d short, %0d long, %0d none",
             seen_events[qkp_pkg::EV_CW], seen_events[qkp_pkg::EV_CCW],
             seen_events[qkp_pkg::EV_SHORT], seen_events[qkp_pkg::EV_LONG],
             seen_events[qkp_pkg::EV_NONE]);
    if (mismatches == 0) begin
      $display("quadrature_knob_with_press_timing test passed");
    end else begin
      $display("quadrature_knob_with_press_timing test failed");
    end
    $finish;
  end

endmodule
